/* design/sdepq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdepq_pkg
// Shared types for the sorted double-ended priority queue: command and
// result words, command and status codes, and the control word that drives
// the cell chain.
// ----------------------------------------------------------------------------
package sdepq_pkg;

  typedef enum logic [1:0] {
    MODE_INSERT      = 2'd0,
    MODE_REMOVE_HIGH = 2'd1,
    MODE_REMOVE_LOW  = 2'd2,
    MODE_PURGE       = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    mode_t              mode;
    logic signed [31:0] value_in;
    logic signed [31:0] priority_in;
  } cmd_word_t;

  typedef struct packed {
    status_t            status;
    logic signed [31:0] removed_value;
    logic signed [31:0] removed_priority;
    logic        [4:0]  entry_count;
    logic               queue_empty;
    logic signed [31:0] top_value;
    logic signed [31:0] bottom_value;
  } rsp_word_t;

  // Broadcast to every cell of the chain.
  typedef struct packed {
    logic               insert_en;  // sorted insert of new_value/new_prio
    logic               pull_en;    // shift every entry one place up
    logic signed [31:0] new_value;
    logic signed [31:0] new_prio;
  } cell_ctrl_t;

endpackage

/* design/sdepq_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdepq_cell
// One position of the sorted chain. Holds a value and priority pair and,
// on a command, keeps it, takes the new pair, or takes a neighbor's pair.
// ----------------------------------------------------------------------------
module sdepq_cell (
  input  logic                  clk,
  input  sdepq_pkg::cell_ctrl_t ctrl,
  input  logic                  occupied,
  input  logic signed [31:0]    prev_value,
  input  logic signed [31:0]    prev_prio,
  input  logic                  prev_ge,
  input  logic signed [31:0]    next_value,
  input  logic signed [31:0]    next_prio,
  output logic signed [31:0]    value,
  output logic signed [31:0]    prio,
  output logic                  ge
);

  logic signed [31:0] value_next;
  logic signed [31:0] prio_next;

  // Stored pair outranks or ties the new one: it stays ahead of it.
  assign ge = occupied && (prio >= ctrl.new_prio);

  always_comb begin
    value_next = value;
    prio_next  = prio;
    if (ctrl.insert_en) begin
      if (!ge && prev_ge) begin
        // first position behind all equal or higher entries: take new pair
        value_next = ctrl.new_value;
        prio_next  = ctrl.new_prio;
      end else if (!ge) begin
        // advance the entry above one place down
        value_next = prev_value;
        prio_next  = prev_prio;
      end
    end else if (ctrl.pull_en) begin
      value_next = next_value;
      prio_next  = next_prio;
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
    prio  <= prio_next;
  end

endmodule

/* design/sorted_double_ended_priority_queue_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_double_ended_priority_queue_core
// Bounded queue of value/priority pairs kept sorted by descending priority
// in a chain of cells, with insert, remove highest, remove lowest and purge.
// ----------------------------------------------------------------------------
// Each command word on cmd yields exactly one result word on rsp. In the
// accept cycle every cell of the chain compares its priority with the new
// one in parallel and keeps, takes the new pair or takes its neighbor's pair,
// so an insert or a remove finishes at the accept edge; in S_RESULT the
// result word is built from the updated chain (top entry, bottom entry
// selected by the count) and loaded into the output register. cmd_ready is
// high again right after, even while that result still waits on rsp; the
// next result is held back only until the output register is free. A new
// command is taken only once the result of the last one is loaded.
// Equal priorities leave the top in arrival order. An insert into a full
// queue is dropped with status full; a remove from an empty queue reports
// status empty and changes nothing. Entries beyond the count hold stale
// data and are never shown.
// ----------------------------------------------------------------------------
module sorted_double_ended_priority_queue_core #(
  parameter int CAPACITY = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cmd_valid,
  output logic                 cmd_ready,
  input  sdepq_pkg::cmd_word_t cmd,
  output logic                 rsp_valid,
  input  logic                 rsp_ready,
  output sdepq_pkg::rsp_word_t rsp
);

  localparam int CW = $clog2(CAPACITY + 1);  // count width
  localparam int IW = $clog2(CAPACITY);      // position index width

  typedef enum logic {
    S_IDLE,
    S_RESULT
  } state_t;

  state_t  state;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;

  // Result fields captured in the accept cycle, finished in S_RESULT.
  sdepq_pkg::status_t pend_status;
  logic signed [31:0] pend_value;
  logic signed [31:0] pend_prio;
  sdepq_pkg::status_t pend_status_next;
  logic signed [31:0] pend_value_next;
  logic signed [31:0] pend_prio_next;

  logic signed [31:0] cell_value [CAPACITY];
  logic signed [31:0] cell_prio  [CAPACITY];
  logic               cell_ge    [CAPACITY];

  sdepq_pkg::cell_ctrl_t ctrl;

  logic               accept;
  logic               full;
  logic               empty;
  logic [CW-1:0]      last_pos;
  logic signed [31:0] bottom_value;
  logic signed [31:0] bottom_prio;
  logic               load_rsp;

  assign cmd_ready = (state == S_IDLE);
  assign accept    = cmd_valid && cmd_ready;
  assign full      = (count == CW'(CAPACITY));
  assign empty     = (count == '0);

  // Bottom entry at the current count: the pre-command count in the accept
  // cycle (remove lowest), the post-command count in S_RESULT.
  assign last_pos     = count - CW'(1);
  assign bottom_value = cell_value[last_pos[IW-1:0]];
  assign bottom_prio  = cell_prio[last_pos[IW-1:0]];

  always_comb begin
    ctrl.insert_en = accept && (cmd.mode == sdepq_pkg::MODE_INSERT) && !full;
    ctrl.pull_en   = accept && (cmd.mode == sdepq_pkg::MODE_REMOVE_HIGH) && !empty;
    ctrl.new_value = cmd.value_in;
    ctrl.new_prio  = cmd.priority_in;
  end

  // Chain of cells: position 0 is the highest priority.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [31:0] prev_value;
    logic signed [31:0] prev_prio;
    logic               prev_ge;
    logic signed [31:0] next_value;
    logic signed [31:0] next_prio;

    if (i == 0) begin : g_first
      // a virtual entry above the top always outranks the new pair
      assign prev_value = cell_value[i];
      assign prev_prio  = cell_prio[i];
      assign prev_ge    = 1'b1;
    end else begin : g_mid
      assign prev_value = cell_value[i-1];
      assign prev_prio  = cell_prio[i-1];
      assign prev_ge    = cell_ge[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign next_value = cell_value[i];
      assign next_prio  = cell_prio[i];
    end else begin : g_inner
      assign next_value = cell_value[i+1];
      assign next_prio  = cell_prio[i+1];
    end

    sdepq_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .occupied   (count > CW'(i)),
      .prev_value (prev_value),
      .prev_prio  (prev_prio),
      .prev_ge    (prev_ge),
      .next_value (next_value),
      .next_prio  (next_prio),
      .value      (cell_value[i]),
      .prio       (cell_prio[i]),
      .ge         (cell_ge[i])
    );
  end

  // Occupancy after the command being accepted.
  always_comb begin
    count_next = count;
    if (accept) begin
      unique case (cmd.mode) inside
        sdepq_pkg::MODE_INSERT: begin
          if (!full) count_next = count + CW'(1);
        end
        sdepq_pkg::MODE_REMOVE_HIGH, sdepq_pkg::MODE_REMOVE_LOW: begin
          if (!empty) count_next = count - CW'(1);
        end
        sdepq_pkg::MODE_PURGE: count_next = '0;
        default: count_next = count;
      endcase
    end
  end

  // Status and removed pair from the pre-command chain.
  always_comb begin
    pend_status_next = sdepq_pkg::ST_OK;
    pend_value_next  = '0;
    pend_prio_next   = '0;
    unique case (cmd.mode)
      sdepq_pkg::MODE_INSERT: begin
        if (full) pend_status_next = sdepq_pkg::ST_FULL;
      end
      sdepq_pkg::MODE_REMOVE_HIGH: begin
        if (empty) begin
          pend_status_next = sdepq_pkg::ST_EMPTY;
        end else begin
          pend_value_next = cell_value[0];
          pend_prio_next  = cell_prio[0];
        end
      end
      sdepq_pkg::MODE_REMOVE_LOW: begin
        if (empty) begin
          pend_status_next = sdepq_pkg::ST_EMPTY;
        end else begin
          pend_value_next = bottom_value;
          pend_prio_next  = bottom_prio;
        end
      end
      sdepq_pkg::MODE_PURGE: pend_status_next = sdepq_pkg::ST_OK;
      default: pend_status_next = sdepq_pkg::ST_OK;
    endcase
  end

  // Capture the pending fields of the accepted command.
  always_ff @(posedge clk) begin
    if (accept) begin
      pend_status <= pend_status_next;
      pend_value  <= pend_value_next;
      pend_prio   <= pend_prio_next;
    end
  end

  // Move the finished word out once the output register is free.
  assign load_rsp = (state == S_RESULT) && (!rsp_valid || rsp_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (load_rsp) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) state <= S_RESULT;
        end
        S_RESULT: begin
          if (load_rsp) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
      // Output register: peeks come from the updated chain.
      if (load_rsp) begin
        rsp.status           <= pend_status;
        rsp.removed_value    <= pend_value;
        rsp.removed_priority <= pend_prio;
        rsp.entry_count      <= 5'(count);
        rsp.queue_empty      <= empty;
        rsp.top_value        <= empty ? 32'sd0 : cell_value[0];
        rsp.bottom_value     <= empty ? 32'sd0 : bottom_value;
      end
    end
  end

endmodule

/* design/sdepq_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdepq_checker
// Port-level checks for the sorted double-ended priority queue, bound to the
// top level.
// ----------------------------------------------------------------------------
module sdepq_checker #(
  parameter int CAPACITY = 16
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 cmd_valid,
  input logic                 cmd_ready,
  input sdepq_pkg::cmd_word_t cmd,
  input logic                 rsp_valid,
  input logic                 rsp_ready,
  input sdepq_pkg::rsp_word_t rsp
);

  // a stalled result word holds
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("result word changed while stalled");

  // a waiting command word holds until taken
  assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_ready |=> cmd_valid && $stable(cmd))
    else $error("command word changed while waiting");

  // after a command is taken the block is not ready in the next cycle
  assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("command taken back to back");

  // an empty queue shows a zero count and zero peeks
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (!rsp.queue_empty || rsp.entry_count == 5'd0) &&
                  (!rsp.queue_empty || (rsp.top_value == 0 && rsp.bottom_value == 0)))
    else $error("empty flag, count and peeks disagree");

  // a dropped insert reports a full queue and no removed pair
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == sdepq_pkg::ST_FULL |->
      rsp.entry_count == 5'(CAPACITY) && rsp.removed_value == 0 &&
      rsp.removed_priority == 0)
    else $error("full status with wrong count or removed pair");

endmodule

bind sorted_double_ended_priority_queue_core sdepq_checker #(.CAPACITY(CAPACITY)) u_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd_valid),
  .cmd_ready (cmd_ready),
  .cmd       (cmd),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);
